// ===== sv/u8d_pkg.sv =====
// Package for the UTF-8 stream decoder.
// Holds the item opcodes, byte-range constants and the result descriptor type.
// No dependencies.
package u8d_pkg;

  // Input item kinds.
  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // Result status codes.
  localparam logic ST_VALID   = 1'b0;
  localparam logic ST_INVALID = 1'b1;

  localparam int CP_W  = 21;
  localparam int CNT_W = 3;

  // Byte classes.
  localparam logic [7:0] ASCII_MAX = 8'h7f;
  localparam logic [7:0] LEAD2_MIN = 8'hc2;
  localparam logic [7:0] LEAD2_MAX = 8'hdf;
  localparam logic [7:0] LEAD3_MIN = 8'he0;
  localparam logic [7:0] LEAD3_MAX = 8'hef;
  localparam logic [7:0] LEAD4_MIN = 8'hf0;
  localparam logic [7:0] LEAD4_MAX = 8'hf4;

  // Scalar value limits.
  localparam logic [CP_W-1:0] MIN_LEN2  = 21'h00080;
  localparam logic [CP_W-1:0] MIN_LEN3  = 21'h00800;
  localparam logic [CP_W-1:0] MIN_LEN4  = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10ffff;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h0d800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h0dfff;

  // Results caused by one item: inv_cnt invalid results, then an optional
  // complete code point.
  typedef struct packed {
    logic [2:0]       inv_cnt;
    logic             has_val;
    logic [CP_W-1:0]  cp;
    logic [CNT_W-1:0] cnt;
  } desc_t;

endpackage

// ===== sv/u8d_decode.sv =====
// Decoder core: sequence state registers and the per-item decode logic.
// Depends on u8d_pkg for the descriptor type and byte-range constants.
module u8d_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_op,
  input  logic [7:0]          item_byte,
  input  logic                commit,
  output u8d_pkg::desc_t      desc,
  output logic                has_result
);

  logic [u8d_pkg::CP_W-1:0] pv_r, pv_nxt;
  logic [2:0]               pe_r, pe_nxt;
  logic [1:0]               ph_r, ph_nxt;

  // Classification of the byte as a fresh lead.
  logic                     s_ascii;
  logic                     s_bad;
  logic [2:0]               s_len;
  logic [u8d_pkg::CP_W-1:0] s_val;

  logic                     pending;
  logic                     is_cont;
  logic [u8d_pkg::CP_W-1:0] cont_val;
  logic [1:0]               cont_held;
  logic                     complete;
  logic [u8d_pkg::CP_W-1:0] minimum;
  logic                     rejected;

  // Lead byte classification.
  always_comb begin
    s_ascii = 1'b0;
    s_bad   = 1'b0;
    s_len   = 3'd0;
    s_val   = '0;
    if (item_byte <= u8d_pkg::ASCII_MAX) begin
      s_ascii = 1'b1;
    end else if (item_byte >= u8d_pkg::LEAD2_MIN && item_byte <= u8d_pkg::LEAD2_MAX) begin
      s_len = 3'd2;
      s_val = {16'd0, item_byte[4:0]};
    end else if (item_byte >= u8d_pkg::LEAD3_MIN && item_byte <= u8d_pkg::LEAD3_MAX) begin
      s_len = 3'd3;
      s_val = {17'd0, item_byte[3:0]};
    end else if (item_byte >= u8d_pkg::LEAD4_MIN && item_byte <= u8d_pkg::LEAD4_MAX) begin
      s_len = 3'd4;
      s_val = {18'd0, item_byte[2:0]};
    end else begin
      s_bad = 1'b1;
    end
  end

  // Continuation byte path and range checks on a finished sequence.
  assign pending   = (pe_r != 3'd0);
  assign is_cont   = (item_byte[7:6] == 2'b10);
  assign cont_val  = {pv_r[u8d_pkg::CP_W-7:0], item_byte[5:0]};
  assign cont_held = ph_r + 2'd1;
  assign complete  = ({1'b0, cont_held} >= pe_r) || (cont_held == 2'd0);

  always_comb begin
    unique case (pe_r)
      3'd2:    minimum = u8d_pkg::MIN_LEN2;
      3'd3:    minimum = u8d_pkg::MIN_LEN3;
      default: minimum = u8d_pkg::MIN_LEN4;
    endcase
  end

  assign rejected = (cont_val < minimum) || (cont_val > u8d_pkg::CP_MAX) ||
                    (cont_val >= u8d_pkg::SURR_LO && cont_val <= u8d_pkg::SURR_HI);

  // Result descriptor and next sequence state.
  always_comb begin
    desc         = '0;
    desc.cnt     = 3'd1;
    pv_nxt       = pv_r;
    pe_nxt       = pe_r;
    ph_nxt       = ph_r;
    if (item_op == u8d_pkg::OP_FLUSH) begin
      desc.inv_cnt = pending ? {1'b0, ph_r} : 3'd0;
      pv_nxt = '0;
      pe_nxt = 3'd0;
      ph_nxt = 2'd0;
    end else if (pending && is_cont) begin
      if (complete) begin
        if (rejected) begin
          desc.inv_cnt = pe_r;
        end else begin
          desc.has_val = 1'b1;
          desc.cp      = cont_val;
          desc.cnt     = pe_r;
        end
        pv_nxt = '0;
        pe_nxt = 3'd0;
        ph_nxt = 2'd0;
      end else begin
        pv_nxt = cont_val;
        ph_nxt = cont_held;
      end
    end else begin
      // Fresh lead, possibly after flushing a broken sequence.
      desc.inv_cnt = (pending ? {1'b0, ph_r} : 3'd0) + {2'd0, s_bad};
      pv_nxt = '0;
      pe_nxt = 3'd0;
      ph_nxt = 2'd0;
      if (s_ascii) begin
        desc.has_val = 1'b1;
        desc.cp      = {13'd0, item_byte};
      end else if (!s_bad) begin
        pv_nxt = s_val;
        pe_nxt = s_len;
        ph_nxt = 2'd1;
      end
    end
  end

  assign has_result = (desc.inv_cnt != 3'd0) || desc.has_val;

  // State update on item commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      pe_r <= 3'd0;
      ph_r <= 2'd0;
    end else if (commit) begin
      pv_r <= pv_nxt;
      pe_r <= pe_nxt;
      ph_r <= ph_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // With nothing pending the held count and gathered bits are clear.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pe_r == 3'd0) |-> (ph_r == 2'd0 && pv_r == '0))
    else $error("idle decoder state not clear");

  // A pending sequence has a legal length and holds fewer bytes than it needs.
  a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
    pending |-> ((pe_r == 3'd2 || pe_r == 3'd3 || pe_r == 3'd4) &&
                 ph_r != 2'd0 && {1'b0, ph_r} < pe_r))
    else $error("pending sequence length out of range");

  // One item never causes more than four results.
  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (desc.inv_cnt + {2'd0, desc.has_val} <= 3'd4))
    else $error("too many results for one item");
`endif

endmodule

// ===== sv/u8d_emit.sv =====
// Result register: holds the descriptor of one item and hands out its results.
// Depends on u8d_pkg for the descriptor type and status codes.
module u8d_emit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  u8d_pkg::desc_t                   desc,
  output logic                             ready,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // code_point[20:0], byte_count[23:21]
  output logic                             out_tuser,  // status
  output logic                             out_tlast
);

  logic [2:0]                  inv_r, inv_nxt;
  logic                        hv_r, hv_nxt;
  logic [u8d_pkg::CP_W-1:0]    cp_r, cp_nxt;
  logic [u8d_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        fire;

  // Invalid results go out first, then the complete code point if any.
  assign out_tvalid = (inv_r != 3'd0) || hv_r;
  assign out_tlast  = (inv_r == 3'd0) || (inv_r == 3'd1 && !hv_r);
  assign out_tuser  = (inv_r != 3'd0) ? u8d_pkg::ST_INVALID : u8d_pkg::ST_VALID;
  assign out_tdata  = (inv_r != 3'd0) ? {3'd1, 21'd0} : {cnt_r, cp_r};

  assign fire  = out_tvalid && out_tready;
  assign ready = !out_tvalid || (out_tready && out_tlast);

  // Count down through the pending results; a new item overwrites when done.
  always_comb begin
    inv_nxt = inv_r;
    hv_nxt  = hv_r;
    cp_nxt  = cp_r;
    cnt_nxt = cnt_r;
    if (fire) begin
      if (inv_r != 3'd0) begin
        inv_nxt = inv_r - 3'd1;
      end else begin
        hv_nxt = 1'b0;
      end
    end
    if (load) begin
      inv_nxt = desc.inv_cnt;
      hv_nxt  = desc.has_val;
      cp_nxt  = desc.cp;
      cnt_nxt = desc.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 3'd0;
      hv_r  <= 1'b0;
    end else begin
      inv_r <= inv_nxt;
      hv_r  <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r  <= cp_nxt;
    cnt_r <= cnt_nxt;
  end

`ifndef NO_ASSERTIONS
  // A complete code point is a Unicode scalar value.
  a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == u8d_pkg::ST_VALID) |->
      (out_tdata[20:0] <= u8d_pkg::CP_MAX &&
       !(out_tdata[20:0] >= u8d_pkg::SURR_LO && out_tdata[20:0] <= u8d_pkg::SURR_HI)))
    else $error("complete result is not a scalar value");

  // A new item is loaded only when the previous one is fully handed out.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ready)
    else $error("result register overwritten early");

  // After a final result is taken without a new load, the register is empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_tlast && !load) |=> !out_tvalid)
    else $error("results left after final result");
`endif

endmodule

// ===== sv/utf8_stream_decoder.sv =====
// UTF-8 stream decoder: one byte item in, decoded code points or invalid marks out.
// Accepted items wait in the input register and are decoded against the sequence
// state; results load into the result register once it can take them. Throughput:
// one item per cycle while each item causes at most one result and out_tready is
// not held low; an item causing several results holds the result register until
// all are taken. Reset (rst_n low, synchronous) drops any pending sequence and
// empties the input and result registers. Depends on u8d_pkg, u8d_decode, u8d_emit.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // code_point[20:0], byte_count[23:21]
  output logic        out_tuser,  // status
  output logic        out_tlast
);

  logic           s1_valid_r, s1_valid_nxt;
  logic           s1_op_r, s1_op_nxt;
  logic [7:0]     s1_byte_r, s1_byte_nxt;
  logic           s1_go;
  logic           in_fire;

  u8d_pkg::desc_t desc;
  logic           has_result;
  logic           emit_ready;

  // The held item moves on when its results fit in the result register.
  assign s1_go     = s1_valid_r && (!has_result || emit_ready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  // Input register.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_op_nxt    = s1_op_r;
    s1_byte_nxt  = s1_byte_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_op_nxt    = in_tuser;
      s1_byte_nxt  = in_tdata;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r   <= s1_op_nxt;
    s1_byte_r <= s1_byte_nxt;
  end

  // Decode of the held item against the sequence state.
  u8d_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_op    (s1_op_r),
    .item_byte  (s1_byte_r),
    .commit     (s1_go),
    .desc       (desc),
    .has_result (has_result)
  );

  // Result register and output sequencing.
  u8d_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_go && has_result),
    .desc       (desc),
    .ready      (emit_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== dv/utf8_stream_decoder_tb.sv =====
// Self-checking testbench for utf8_stream_decoder: drives byte and flush items,
// predicts the decoded code points and invalid marks, and checks every result.
// Depends on u8d_pkg and the utf8_stream_decoder RTL.
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned LONG_STALL = 400;

  typedef struct {
    u8d_pkg::op_t op;
    logic [7:0]   b;
  } byte_item_t;

  typedef struct {
    logic                      status;
    logic [u8d_pkg::CP_W-1:0]  cp;
    logic [u8d_pkg::CNT_W-1:0] cnt;
    logic                      last;
  } cp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  utf8_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Items waiting for the driver and results waiting for the decoder.
  byte_item_t  byte_q[$];
  cp_result_t  decoded_q[$];
  cp_result_t  step_q[$];

  // Decoder state as the predictor sees it.
  logic [u8d_pkg::CP_W-1:0] seq_value = '0;
  logic [2:0]               seq_len = '0;
  logic [1:0]               seq_held = '0;

  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          in_fire = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned stall_reqs = 0;
  int unsigned stall_served = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count = 0;
  int unsigned n_pushed = 0;
  int unsigned n_accepted = 0;
  int unsigned n_flush = 0;
  int unsigned n_checked = 0;
  int unsigned n_invalid = 0;

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Result collection for one item; the block never gives more than four.
  task automatic add_result(input logic status, input logic [u8d_pkg::CP_W-1:0] cp,
                            input logic [u8d_pkg::CNT_W-1:0] cnt);
    cp_result_t r;
    if (step_q.size() < 4) begin
      r.status = status;
      r.cp = cp;
      r.cnt = cnt;
      r.last = 1'b0;
      step_q.push_back(r);
    end
  endtask

  task automatic add_invalid(input int unsigned how_many);
    for (int unsigned i = 0; i < how_many; i++) add_result(u8d_pkg::ST_INVALID, '0, 3'd1);
  endtask

  task automatic clear_seq();
    seq_value = '0;
    seq_len = '0;
    seq_held = '0;
  endtask

  // A byte seen with no sequence open: ASCII, a lead byte, or a bad lead.
  task automatic open_seq(input logic [7:0] b);
    if (b <= u8d_pkg::ASCII_MAX) begin
      add_result(u8d_pkg::ST_VALID, {13'd0, b}, 3'd1);
    end else if (b >= u8d_pkg::LEAD2_MIN && b <= u8d_pkg::LEAD2_MAX) begin
      seq_len = 3'd2;
      seq_value = {16'd0, b[4:0]};
      seq_held = 2'd1;
    end else if (b >= u8d_pkg::LEAD3_MIN && b <= u8d_pkg::LEAD3_MAX) begin
      seq_len = 3'd3;
      seq_value = {17'd0, b[3:0]};
      seq_held = 2'd1;
    end else if (b >= u8d_pkg::LEAD4_MIN && b <= u8d_pkg::LEAD4_MAX) begin
      seq_len = 3'd4;
      seq_value = {18'd0, b[2:0]};
      seq_held = 2'd1;
    end else begin
      add_invalid(1);
    end
  endtask

  // Works out the results of one accepted item and queues them.
  task automatic decode_item(input u8d_pkg::op_t op, input logic [7:0] b);
    logic [u8d_pkg::CP_W-1:0] minimum;
    cp_result_t               r;
    step_q.delete();
    if (op == u8d_pkg::OP_FLUSH) begin
      if (seq_len != 0) add_invalid(32'(seq_held));
      clear_seq();
    end else if (seq_len == 0) begin
      open_seq(b);
    end else if (b[7:6] == 2'b10) begin
      seq_value = {seq_value[u8d_pkg::CP_W-7:0], b[5:0]};
      seq_held = seq_held + 2'd1;
      // The held count wraps to zero on the fourth byte of a long sequence.
      if ({1'b0, seq_held} >= seq_len || seq_held == 2'd0) begin
        minimum = (seq_len == 3'd2) ? u8d_pkg::MIN_LEN2 :
                  (seq_len == 3'd3) ? u8d_pkg::MIN_LEN3 : u8d_pkg::MIN_LEN4;
        if (seq_value < minimum || seq_value > u8d_pkg::CP_MAX ||
            (seq_value >= u8d_pkg::SURR_LO && seq_value <= u8d_pkg::SURR_HI)) begin
          add_invalid(32'(seq_len));
        end else begin
          add_result(u8d_pkg::ST_VALID, seq_value, seq_len);
        end
        clear_seq();
      end
    end else begin
      // Broken sequence: drop what is held, then take this byte as a new lead.
      add_invalid(32'(seq_held));
      clear_seq();
      open_seq(b);
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endtask

  function automatic int unsigned pick_gap(input bit en);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!en || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: holds an item until it is taken, then idles or offers the next.
  always @(negedge clk) begin : drive
    byte_item_t item;
    if (rst_n) begin
      if (in_tvalid && !in_fire) begin
        // Item still on offer.
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        item = byte_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= item.op;
        in_tdata <= item.b;
        tx_gap <= pick_gap(tx_idle_en);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus an occasional long hold-off.
  always @(negedge clk) begin : receive
    int unsigned r;
    r = $urandom_range(0, 99);
    if (stall_reqs != stall_served) begin
      stall_served <= stall_served + 1;
      rx_stall <= LONG_STALL;
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_tready <= 1'b0;
    end else if (!rx_idle_en || r < 65) begin
      out_tready <= 1'b1;
    end else if (r < 95) begin
      out_tready <= 1'b0;
    end else begin
      rx_stall <= $urandom_range(8, 40);
      out_tready <= 1'b0;
    end
  end

  // Monitor: predicts on each accepted item, checks each accepted result.
  always @(posedge clk) begin : monitor
    cp_result_t want;
    bit         out_fire;
    in_fire = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) begin
      n_accepted++;
      if (in_tuser == u8d_pkg::OP_FLUSH) n_flush++;
      decode_item(in_tuser ? u8d_pkg::OP_FLUSH : u8d_pkg::OP_DATA, in_tdata);
    end
    if (out_fire) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result, data", 32'(out_tdata), 0);
      end else begin
        want = decoded_q.pop_front();
        n_checked++;
        if (want.status == u8d_pkg::ST_INVALID) n_invalid++;
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[20:0] !== want.cp)
          report_mismatch("code_point", 32'(out_tdata[20:0]), 32'(want.cp));
        if (out_tdata[23:21] !== want.cnt)
          report_mismatch("byte_count", 32'(out_tdata[23:21]), 32'(want.cnt));
        if (out_tlast !== want.last)
          report_mismatch("last", 32'(out_tlast), 32'(want.last));
      end
    end
    // Watchdog: work outstanding but nothing moving on either side.
    if (in_fire || out_fire || (byte_q.size() == 0 && !in_tvalid && decoded_q.size() == 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] timeout: no handshake for %0d cycles", $time, quiet_cycles);
        $display("utf8_stream_decoder_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic push_item(input u8d_pkg::op_t op, input logic [7:0] b);
    byte_item_t item;
    item.op = op;
    item.b = b;
    byte_q.push_back(item);
    n_pushed++;
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Encodes a scalar value in len bytes and sends the first keep of them.
  task automatic push_seq(input logic [u8d_pkg::CP_W-1:0] cp, input int unsigned len,
                          input int unsigned keep);
    logic [7:0] enc[4];
    enc = '{default: 8'h00};
    case (len)
      1: enc[0] = cp[7:0];
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int unsigned i = 0; i < keep; i++) push_item(u8d_pkg::OP_DATA, enc[i]);
  endtask

  function automatic logic [u8d_pkg::CP_W-1:0] rand_scalar(input int unsigned len);
    logic [u8d_pkg::CP_W-1:0] lo, hi, cp;
    case (len)
      1: begin lo = 21'h0;             hi = 21'h7f;         end
      2: begin lo = u8d_pkg::MIN_LEN2; hi = 21'h7ff;        end
      3: begin lo = u8d_pkg::MIN_LEN3; hi = 21'hffff;       end
      default: begin lo = u8d_pkg::MIN_LEN4; hi = u8d_pkg::CP_MAX; end
    endcase
    case ($urandom_range(0, 19))
      0: cp = lo;
      1: cp = hi;
      default: cp = u8d_pkg::CP_W'($urandom_range(32'(lo), 32'(hi)));
    endcase
    // Move surrogates up into the valid top of the three-byte range.
    if (cp >= u8d_pkg::SURR_LO && cp <= u8d_pkg::SURR_HI) cp = cp ^ 21'h02000;
    return cp;
  endfunction

  // One random unit: mostly well-formed text, the rest broken or noise.
  task automatic push_random_unit();
    int unsigned r, len;
    r = $urandom_range(0, 99);
    len = $urandom_range(1, 4);
    if (r < 70) begin
      push_seq(rand_scalar(len), len, len);
    end else if (r < 78) begin
      // Truncated sequence; the next unit or a flush breaks it.
      len = $urandom_range(2, 4);
      push_seq(rand_scalar(len), len, $urandom_range(1, len - 1));
      if ($urandom_range(0, 2) == 0)
        push_item(u8d_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
    end else if (r < 85) begin
      // Full sequences whose value is rejected, or a C0/C1 lead and a continuation byte.
      case ($urandom_range(0, 4))
        0: begin
          push_item(u8d_pkg::OP_DATA, u8d_pkg::LEAD3_MIN);
          push_item(u8d_pkg::OP_DATA, 8'($urandom_range(8'h80, 8'h9f)));
          push_item(u8d_pkg::OP_DATA, rand_cont());
        end
        1: begin
          push_item(u8d_pkg::OP_DATA, u8d_pkg::LEAD4_MIN);
          push_item(u8d_pkg::OP_DATA, 8'($urandom_range(8'h80, 8'h8f)));
          push_item(u8d_pkg::OP_DATA, rand_cont());
          push_item(u8d_pkg::OP_DATA, rand_cont());
        end
        2: begin
          push_item(u8d_pkg::OP_DATA, 8'hed);
          push_item(u8d_pkg::OP_DATA, 8'($urandom_range(8'ha0, 8'hbf)));
          push_item(u8d_pkg::OP_DATA, rand_cont());
        end
        3: begin
          push_item(u8d_pkg::OP_DATA, u8d_pkg::LEAD4_MAX);
          push_item(u8d_pkg::OP_DATA, 8'($urandom_range(8'h90, 8'hbf)));
          push_item(u8d_pkg::OP_DATA, rand_cont());
          push_item(u8d_pkg::OP_DATA, rand_cont());
        end
        default: begin
          push_item(u8d_pkg::OP_DATA, 8'($urandom_range(8'hc0, 8'hc1)));
          push_item(u8d_pkg::OP_DATA, rand_cont());
        end
      endcase
    end else if (r < 91) begin
      push_item(u8d_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3))
        push_item($urandom_range(0, 3) == 0 ? u8d_pkg::OP_FLUSH : u8d_pkg::OP_DATA,
                  8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_tvalid || decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic fill_random(input int unsigned upto);
    while (n_pushed < upto) push_random_unit();
  endtask

  // Stimulus sequence and end of run.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: ASCII ends, shortest and longest valid forms.
    push_item(u8d_pkg::OP_DATA, 8'h00);
    push_item(u8d_pkg::OP_DATA, 8'h7f);
    push_seq(21'h00080, 2, 2);
    push_seq(21'h0ffff, 3, 3);
    push_seq(u8d_pkg::CP_MAX, 4, 4);
    // Bad leads with nothing pending.
    push_item(u8d_pkg::OP_DATA, 8'h80);
    push_item(u8d_pkg::OP_DATA, 8'hff);
    // Three held bytes broken by a bad lead: four invalid results at once.
    push_item(u8d_pkg::OP_DATA, 8'hf0);
    push_item(u8d_pkg::OP_DATA, 8'h90);
    push_item(u8d_pkg::OP_DATA, 8'h80);
    push_item(u8d_pkg::OP_DATA, 8'hc0);
    // Surrogate rejected as a whole sequence.
    push_item(u8d_pkg::OP_DATA, 8'hed);
    push_item(u8d_pkg::OP_DATA, 8'ha0);
    push_item(u8d_pkg::OP_DATA, 8'h80);
    // Broken sequence whose breaking byte opens a new one.
    push_item(u8d_pkg::OP_DATA, 8'he2);
    push_item(u8d_pkg::OP_DATA, 8'hc3);
    push_item(u8d_pkg::OP_DATA, 8'ha9);
    // Flush with nothing pending, then with two bytes pending.
    push_item(u8d_pkg::OP_FLUSH, 8'h00);
    push_item(u8d_pkg::OP_DATA, 8'he2);
    push_item(u8d_pkg::OP_DATA, 8'h82);
    push_item(u8d_pkg::OP_FLUSH, 8'hff);
    // Sender pauses here until every result is back.
    wait_drained();

    // Random with idling on both sides.
    fill_random(200);
    wait_drained();

    // Full rate on both sides.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    fill_random(300);
    wait_drained();

    // Receiver holds off for a long stretch while the sender keeps going.
    rx_idle_en = 1'b1;
    stall_reqs++;
    fill_random(360);
    wait_drained();

    tx_idle_en = 1'b1;
    fill_random(460);
    wait_drained();
    repeat (8) @(posedge clk);

    if (decoded_q.size() != 0) report_mismatch("results never seen", 0, decoded_q.size());
    $display("Sent %0d items (%0d flushes); checked %0d results, %0d of them invalid.",
             n_accepted, n_flush, n_checked, n_invalid);
    $display("Covered idle, full-rate and long back-pressure phases; %0d mismatches.",
             err_count);
    if (err_count == 0) begin
      $display("utf8_stream_decoder_tb: done, clean");
    end else begin
      $display("utf8_stream_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
